// ===== src/bsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared widths, codes and reset values for the bitmap span fill block.
// ----------------------------------------------------------------------------
package bsf_pkg;

  // Default size of the byte store.
  localparam int FB_BYTES_DEF = 4096;

  // Field widths of the command and response transfers.
  localparam int MODE_W  = 2;
  localparam int X_W     = 9;
  localparam int Y_W     = 12;
  localparam int RADDR_W = 12;
  localparam int DATA_W  = 8;

  // Configuration register widths and port widths.
  localparam int RB_W       = 7;
  localparam int ROWS_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;

  // Register reset values.
  localparam logic [RB_W-1:0]   ROW_BYTES_RST = 7'd8;
  localparam logic [ROWS_W-1:0] ROWS_RST      = 13'd64;

  // Response status codes.
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

endpackage

// ===== src/bsf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_in_if
// Command channel: valid, ready and one command payload.
// ----------------------------------------------------------------------------
interface bsf_in_if;
  import bsf_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [X_W-1:0]     start_x;
  logic [Y_W-1:0]     start_y;
  logic [X_W-1:0]     end_x;
  logic [Y_W-1:0]     end_y;
  logic [RADDR_W-1:0] read_address;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, read_address,
                  input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, read_address,
                  output ready);
endinterface

// ===== src/bsf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_out_if
// Response channel: valid, ready, returned byte and status.
// ----------------------------------------------------------------------------
interface bsf_out_if;
  import bsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// ===== src/bsf_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface bsf_cfg_if;
  import bsf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bitmap_span_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_span_fill
// One-bit-per-pixel framebuffer with linear run fill, clear and byte read.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer carries
//  --------  ---------  ---------------------------------------------------
//  in_ch     sink       mode, start_x, start_y, end_x, end_y, read_address
//  out_ch    source     read_data, status (one response per command)
//  cfg_ch    sink       index (0 row_bytes, 1 rows), data
//
//  A draw runs the two multiplies, the check, the head byte, the filled bytes
//  (one write per byte on the single write port) and the tail byte; a rejected
//  draw ends at the check, a draw inside one byte at the head. A clear writes
//  each byte in use, a read fetches one byte, the unused code is rejected. After
//  reset the whole store is swept to zero with in_ch.ready low. A response waits
//  in the output register while the next command runs; only a second response then stalls.
//
module bitmap_span_fill #(
  parameter int FB_BYTES = bsf_pkg::FB_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bsf_in_if.sink    in_ch,
  bsf_out_if.source out_ch,
  bsf_cfg_if.sink   cfg_ch
);
  import bsf_pkg::*;

  // Store address width, and the width of byte indexes computed from a run
  // (row_bytes * row + column byte), which can exceed the store.
  localparam int AW = $clog2(FB_BYTES);
  localparam int BW = RB_W + ROWS_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MUL1, S_MUL2, S_CHECK, S_HEAD, S_FILL, S_TAIL,
    S_CLRSET, S_CLEAR, S_READ, S_RDATA, S_RESP
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [RB_W-1:0]   row_bytes_r;
  logic [ROWS_W-1:0] rows_r;

  // Captured command.
  logic [MODE_W-1:0]  mode_r;
  logic [X_W-1:0]     sx_r;
  logic [Y_W-1:0]     sy_r;
  logic [X_W-1:0]     ex_r;
  logic [Y_W-1:0]     ey_r;
  logic [RADDR_W-1:0] addr_r;

  // Working registers: product, first and last byte, walk pointer.
  logic [BW-1:0] prod_r;
  logic [BW-1:0] b1_r;
  logic [BW-1:0] b2_r;
  logic [AW-1:0] cur_r;
  logic [AW-1:0] last_r;

  // Pending response and the output register.
  logic [DATA_W-1:0] res_data_r;
  logic              res_status_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_status_r;

  // Store ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Shared multiplier: row_bytes times a row number, or times rows for a
  // clear. One product per cycle, registered in prod_r.
  logic [ROWS_W-1:0] mul_a;
  logic [BW-1:0]     mul_p;

  always_comb begin
    mul_a = ROWS_W'(sy_r);
    if (state_r == S_MUL2) begin
      mul_a = ROWS_W'(ey_r);
    end else if (mode_r == MODE_CLEAR) begin
      mul_a = rows_r;
    end
  end

  assign mul_p = BW'(mul_a) * BW'(row_bytes_r);

  // Run checks, evaluated in S_CHECK when the last byte index is formed.
  logic [BW-1:0]     b2_calc;
  logic [RB_W+2:0]   width_px;
  logic              range_bad;
  logic              reversed;
  logic              beyond;
  logic              reject;
  logic [7:0]        head_mask;
  logic [7:0]        tail_mask;
  logic [AW-1:0]     b1_a;
  logic [AW-1:0]     b2_a;

  assign b2_calc  = prod_r + BW'(ex_r[X_W-1:3]);
  assign width_px = {row_bytes_r, 3'b000};
  assign range_bad = ((RB_W+3)'(sx_r) >= width_px) || ((RB_W+3)'(ex_r) >= width_px) ||
                     (ROWS_W'(sy_r) >= rows_r) || (ROWS_W'(ey_r) >= rows_r);
  // Compare the linear pixel indexes as {byte, bit} pairs.
  assign reversed = {b1_r, sx_r[2:0]} > {b2_calc, ex_r[2:0]};
  assign beyond   = b2_calc >= BW'(FB_BYTES);
  assign reject   = range_bad || reversed || beyond;

  assign head_mask = 8'hFF >> sx_r[2:0];
  assign tail_mask = 8'hFF << (3'd7 - ex_r[2:0]);
  assign b1_a      = AW'(b1_r);
  assign b2_a      = AW'(b2_r);

  // Clear length: the product limited to the store.
  logic [BW-1:0] clr_last;
  assign clr_last = (prod_r > BW'(FB_BYTES)) ? BW'(FB_BYTES - 1) : (prod_r - BW'(1));

  logic read_oob;
  assign read_oob = (BW'(addr_r) >= BW'(FB_BYTES));

  // Store access per state. Each read is issued in the state before the one
  // that uses its data; no write ever lands on an entry whose read is still in flight, as
  // the head byte, the filled bytes and the tail byte are distinct entries.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = 8'h00;
    mem_raddr = cur_r;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_CHECK: begin
        mem_raddr = b1_a;
      end
      S_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = b1_a;
        mem_wdata = (b1_r == b2_r) ? (mem_rdata | (head_mask & tail_mask))
                                   : (mem_rdata | head_mask);
      end
      S_FILL: begin
        // At the last byte only the read for the tail merge is issued.
        mem_we    = (cur_r != b2_a);
        mem_wdata = 8'hFF;
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = b2_a;
        mem_wdata = mem_rdata | tail_mask;
      end
      S_READ: begin
        mem_raddr = AW'(addr_r);
      end
      default: begin
      end
    endcase
  end

  bsf_fb_ram #(
    .DEPTH (FB_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cur_r        <= '0;
      row_bytes_r  <= ROW_BYTES_RST;
      rows_r       <= ROWS_RST;
      mode_r       <= MODE_DRAW;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_ROW_BYTES) begin
          row_bytes_r <= cfg_ch.data[RB_W-1:0];
        end else if (cfg_ch.index == CFG_ROWS) begin
          rows_r <= cfg_ch.data[ROWS_W-1:0];
        end
      end

      // The output register empties on a transfer, unless the response state
      // loads the next response into it in the same cycle.
      if (out_ch.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_INIT: begin
          cur_r <= cur_r + AW'(1);
          if (cur_r == AW'(FB_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r       <= in_ch.mode;
            sx_r         <= in_ch.start_x;
            sy_r         <= in_ch.start_y;
            ex_r         <= in_ch.end_x;
            ey_r         <= in_ch.end_y;
            addr_r       <= in_ch.read_address;
            res_data_r   <= '0;
            unique case (in_ch.mode)
              MODE_DRAW, MODE_CLEAR: begin
                res_status_r <= STATUS_DONE;
                state_r      <= S_MUL1;
              end
              MODE_READ: begin
                res_status_r <= STATUS_DONE;
                state_r      <= S_READ;
              end
              default: begin
                res_status_r <= STATUS_REJECT;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_MUL1: begin
          prod_r  <= mul_p;
          state_r <= (mode_r == MODE_CLEAR) ? S_CLRSET : S_MUL2;
        end
        S_MUL2: begin
          b1_r    <= prod_r + BW'(sx_r[X_W-1:3]);
          prod_r  <= mul_p;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          b2_r <= b2_calc;
          if (reject) begin
            res_status_r <= STATUS_REJECT;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur_r   <= b1_a + AW'(1);
          state_r <= (b1_r == b2_r) ? S_RESP : S_FILL;
        end
        S_FILL: begin
          if (cur_r == b2_a) begin
            state_r <= S_TAIL;
          end else begin
            cur_r <= cur_r + AW'(1);
          end
        end
        S_TAIL: begin
          state_r <= S_RESP;
        end
        S_CLRSET: begin
          cur_r  <= '0;
          last_r <= AW'(clr_last);
          state_r <= (prod_r == '0) ? S_RESP : S_CLEAR;
        end
        S_CLEAR: begin
          cur_r <= cur_r + AW'(1);
          if (cur_r == last_r) begin
            state_r <= S_RESP;
          end
        end
        S_READ: begin
          if (read_oob) begin
            res_status_r <= STATUS_REJECT;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_RDATA;
          end
        end
        S_RDATA: begin
          res_data_r <= mem_rdata;
          state_r    <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= res_data_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.status    = out_status_r;

endmodule

// ===== src/bsf_fb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_fb_ram
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsf_fb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks for the bitmap span fill block, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_status
);

  // A response held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_status))
    else $error("response payload changed while stalled");

  // A rejected command never returns data.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_data == 8'h00)
    else $error("rejected response carries data");

  // Commands are worked one at a time.
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in progress");

  // The store is being swept right after reset, so no command is taken.
  a_init_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("command taken during the reset sweep");

endmodule

bind bitmap_span_fill bsf_checker u_bsf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_status    (out_ch.status)
);
